>>> rtl/assert_macros.svh
// Assertion macros used by the tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/erdt_pkg.sv
// Types and constants of the event ring dequeue tracker.
package erdt_pkg;

    localparam int MAX_SEGMENTS_DEF        = 8;
    localparam int ENTRIES_PER_SEGMENT_DEF = 256;
    localparam int ENTRIES_PER_SEGMENT_MAX = 4096;

    localparam int CODE_W    = 8;
    localparam int CNT_W     = 4;
    localparam int SEG_OUT_W = 3;
    localparam int OFF_OUT_W = 8;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic CMD_CHECK   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // Register index taken from paddr[2].
    localparam logic REG_SEGMENT_COUNT = 1'b0;

    localparam logic [CNT_W-1:0] SEGMENT_COUNT_RST = 4'd1;

    typedef struct packed {
        logic                 entry_valid;
        logic [SEG_OUT_W-1:0] segment_index;
        logic [OFF_OUT_W-1:0] entry_offset;
        logic                 cycle_state;
        logic                 reeval_pending;
    } res_t;

endpackage

>>> rtl/event_ring_dequeue_tracker.sv
// Dequeue tracker for the consumer side of a multi-segment event ring.
// Each result is registered in the output register, or in the skid register while m_ready is low.
// Throughput: one item per cycle while s_ready is high; a skid register holds one result while m_ready is low.
// s_ready drops only while both the output and the skid register are full.
// Reset (aresetn low, synchronous): segment 0, offset 0, cycle state 1,
// no re-evaluation pending, every segment on its first pass, segment_count 1.
`include "assert_macros.svh"

module event_ring_dequeue_tracker
    import erdt_pkg::*;
#(
    parameter int MAX_SEGMENTS        = MAX_SEGMENTS_DEF,
    parameter int ENTRIES_PER_SEGMENT = ENTRIES_PER_SEGMENT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_cmd,
    input  logic                 s_entry_cycle,
    input  logic [CODE_W-1:0]    s_entry_code,
    input  logic [CODE_W-1:0]    s_next_first_code,
    input  logic                 s_ring_first_cycle,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_entry_valid,
    output logic [SEG_OUT_W-1:0] m_segment_index,
    output logic [OFF_OUT_W-1:0] m_entry_offset,
    output logic                 m_cycle_state,
    output logic                 m_reeval_pending
);

    localparam int SEG_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int OFF_W = $clog2(ENTRIES_PER_SEGMENT);
    localparam logic [OFF_W-1:0] LAST_OFF = OFF_W'(ENTRIES_PER_SEGMENT - 1);
    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_SEGMENTS);

    // configuration
    logic [CNT_W-1:0] seg_cnt_reg;
    logic             cfg_wr;

    // tracker state
    logic [SEG_W-1:0]        seg_reg,    seg_next;
    logic [OFF_W-1:0]        off_reg,    off_next;
    logic                    cycle_reg,  cycle_next;
    logic                    reeval_reg, reeval_next;
    logic [MAX_SEGMENTS-1:0] marks_reg,  marks_next;

    // output side
    res_t res_reg, skid_reg, res_new;
    logic m_valid_reg,    m_valid_next;
    logic skid_valid_reg, skid_valid_next;

    logic             s_xfer, m_xfer;
    logic [CNT_W-1:0] active_cnt;
    logic [SEG_W:0]   seg_inc;
    logic             at_last_seg;
    logic             next_fresh;
    logic             chk_valid;
    logic [SEG_W+SEG_OUT_W-1:0] seg_ext;
    logic [OFF_W+OFF_OUT_W-1:0] off_ext;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SEGMENT_COUNT);

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_SEGMENT_COUNT) begin
            prdata = {{(PDATA_W-CNT_W){1'b0}}, seg_cnt_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_cnt_reg <= SEGMENT_COUNT_RST;
        end else if (cfg_wr) begin
            seg_cnt_reg <= pwdata[CNT_W-1:0];
        end
    end

    // ---------------- step logic ----------------
    assign s_ready = !skid_valid_reg;
    assign s_xfer  = s_valid && s_ready;
    assign m_xfer  = m_valid_reg && m_ready;

    always_comb begin
        active_cnt = seg_cnt_reg;
        if (active_cnt == '0) begin
            active_cnt = 4'd1;
        end
        if (active_cnt > MAX_CNT) begin
            active_cnt = MAX_CNT;
        end
    end

    assign seg_inc     = {1'b0, seg_reg} + 1'b1;
    assign at_last_seg = (CNT_W'(seg_inc) >= active_cnt);
    assign next_fresh  = marks_reg[seg_inc[SEG_W-1:0]] && (s_next_first_code == '0);
    assign chk_valid   = !reeval_reg &&
                         (marks_reg[seg_reg] ? (s_entry_code != '0)
                                             : (s_entry_cycle == cycle_reg));

    always_comb begin
        seg_next    = seg_reg;
        off_next    = off_reg;
        cycle_next  = cycle_reg;
        reeval_next = reeval_reg;
        marks_next  = marks_reg;
        if (s_xfer && s_cmd == CMD_ADVANCE) begin
            reeval_next = 1'b0;
            priority if (off_reg != LAST_OFF) begin
                off_next = off_reg + 1'b1;
            end else if (!at_last_seg && !next_fresh) begin
                marks_next[seg_reg] = 1'b0;
                seg_next = seg_inc[SEG_W-1:0];
                off_next = '0;
            end else if (!at_last_seg && (s_ring_first_cycle == cycle_reg)) begin
                // fresh segment not yet written: hold position, re-evaluate later
                reeval_next = 1'b1;
            end else begin
                marks_next[seg_reg] = 1'b0;
                seg_next   = '0;
                off_next   = '0;
                cycle_next = !cycle_reg;
            end
        end
    end

    assign seg_ext = {{SEG_OUT_W{1'b0}}, seg_next};
    assign off_ext = {{OFF_OUT_W{1'b0}}, off_next};

    always_comb begin
        res_new.entry_valid    = (s_cmd == CMD_CHECK) ? chk_valid : 1'b0;
        res_new.segment_index  = seg_ext[SEG_OUT_W-1:0];
        res_new.entry_offset   = off_ext[OFF_OUT_W-1:0];
        res_new.cycle_state    = cycle_next;
        res_new.reeval_pending = reeval_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg    <= '0;
            off_reg    <= '0;
            cycle_reg  <= 1'b1;
            reeval_reg <= 1'b0;
            marks_reg  <= '1;
        end else begin
            seg_reg    <= seg_next;
            off_reg    <= off_next;
            cycle_reg  <= cycle_next;
            reeval_reg <= reeval_next;
            marks_reg  <= marks_next;
        end
    end

    // ---------------- output register and skid ----------------
    always_comb begin
        m_valid_next    = m_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (m_xfer || !m_valid_reg) begin
            m_valid_next    = skid_valid_reg || s_xfer;
            skid_valid_next = 1'b0;
        end else if (s_xfer) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_xfer || !m_valid_reg) begin
            // drain the skid first, else load the fresh result
            res_reg <= skid_valid_reg ? skid_reg : res_new;
        end
        if (s_xfer && m_valid_reg && !m_xfer) begin
            skid_reg <= res_new;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_entry_valid    = res_reg.entry_valid;
    assign m_segment_index  = res_reg.segment_index;
    assign m_entry_offset   = res_reg.entry_offset;
    assign m_cycle_state    = res_reg.cycle_state;
    assign m_reeval_pending = res_reg.reeval_pending;

    // ---------------- assertions ----------------
    `ASSERT_IMPLY(a_skid_needs_out, skid_valid_reg, m_valid_reg, "skid full while output empty")
    `ASSERT_IMPLY(a_reeval_holds_pos, $rose(reeval_reg), $stable(seg_reg) && $stable(off_reg) && $stable(cycle_reg), "deferred advance moved the position")
    `ASSERT_IMPLY(a_wrap_to_start, cycle_reg != $past(cycle_reg), seg_reg == '0 && off_reg == '0, "cycle state toggled away from ring start")
    `ASSERT_NEXT(a_out_hold, m_valid_reg && !m_ready, m_valid_reg && $stable(res_reg), "stalled result changed")

endmodule

>>> tb/event_ring_dequeue_tracker_tb.sv
// Self-checking testbench for the event ring dequeue tracker: directed and random items.
`timescale 1ns / 100ps

module event_ring_dequeue_tracker_tb;
    import erdt_pkg::*;

    localparam int ENTRY_COUNT    = ENTRIES_PER_SEGMENT_DEF;
    localparam int SEGMENT_LIMIT  = MAX_SEGMENTS_DEF;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int ADVANCE_PCT    = 92;
    localparam int ITEM_CAP       = 2048;
    localparam int PHASE_ITEMS    = 165;

    localparam logic [PADDR_W-1:0] SEG_COUNT_ADDR = PADDR_W'(4 * REG_SEGMENT_COUNT);
    localparam logic [PADDR_W-1:0] UNUSED_ADDR    = PADDR_W'(4);

    typedef struct packed {
        logic              cmd;
        logic              entry_cycle;
        logic [CODE_W-1:0] entry_code;
        logic [CODE_W-1:0] next_first_code;
        logic              ring_first_cycle;
    } ring_item_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;

    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_cmd = CMD_CHECK;
    logic                 s_entry_cycle = 1'b0;
    logic [CODE_W-1:0]    s_entry_code = '0;
    logic [CODE_W-1:0]    s_next_first_code = '0;
    logic                 s_ring_first_cycle = 1'b0;

    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_entry_valid;
    logic [SEG_OUT_W-1:0] m_segment_index;
    logic [OFF_OUT_W-1:0] m_entry_offset;
    logic                 m_cycle_state;
    logic                 m_reeval_pending;

    // Dequeue position as the tracker should see it
    logic [2:0]           ring_seg;
    int unsigned          ring_off;
    logic                 ring_cycle;
    logic                 ring_reeval;
    logic [7:0]           first_pass;
    logic [CNT_W-1:0]     ring_seg_count;

    // Pending items and predicted results, each filled at _wr and drained at _rd
    ring_item_t           item_mem [ITEM_CAP];
    int                   item_wr = 0;
    int                   item_rd = 0;
    res_t                 pred_mem [ITEM_CAP];
    int                   pred_wr = 0;
    int                   pred_rd = 0;
    ring_item_t           offered;
    res_t                 want;

    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    logic                 pressure_armed = 1'b0;
    logic                 pressure_done = 1'b0;
    int                   hold_left = 0;
    int                   quiet_cycles = 0;

    int                   error_count = 0;
    int                   results_checked = 0;
    int                   check_count = 0;
    int                   advance_count = 0;
    int                   wrap_count = 0;
    int                   move_count = 0;
    int                   defer_count = 0;
    int                   reg_accesses = 0;

    event_ring_dequeue_tracker u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_cmd              (s_cmd),
        .s_entry_cycle      (s_entry_cycle),
        .s_entry_code       (s_entry_code),
        .s_next_first_code  (s_next_first_code),
        .s_ring_first_cycle (s_ring_first_cycle),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_entry_valid      (m_entry_valid),
        .m_segment_index    (m_segment_index),
        .m_entry_offset     (m_entry_offset),
        .m_cycle_state      (m_cycle_state),
        .m_reeval_pending   (m_reeval_pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic int unsigned segments_in_use();
        int unsigned n;
        n = int'({28'd0, ring_seg_count});
        if (n == 0) n = 1;
        if (n > SEGMENT_LIMIT) n = SEGMENT_LIMIT;
        return n;
    endfunction

    // Retire the current segment and restart the ring on the other cycle state.
    function automatic void wrap_ring();
        first_pass[ring_seg] = 1'b0;
        ring_cycle = ~ring_cycle;
        ring_seg = '0;
        ring_off = 0;
        wrap_count++;
    endfunction

    function automatic res_t dequeue_step(ring_item_t it);
        res_t        r;
        logic        valid;
        int unsigned nxt;
        valid = 1'b0;
        if (it.cmd == CMD_CHECK) begin
            check_count++;
            if (ring_reeval)
                valid = 1'b0;
            else if (first_pass[ring_seg])
                valid = (it.entry_code != 0);
            else
                valid = (it.entry_cycle == ring_cycle);
        end else begin
            advance_count++;
            ring_reeval = 1'b0;
            if (ring_off + 1 < ENTRY_COUNT) begin
                ring_off++;
            end else begin
                nxt = ring_seg + 1;
                if (nxt >= segments_in_use()) begin
                    wrap_ring();
                end else if (first_pass[nxt] && it.next_first_code == 0) begin
                    // Race with a segment just added: segment 0 decides, or hold in place
                    if (it.ring_first_cycle == ring_cycle) begin
                        ring_reeval = 1'b1;
                        defer_count++;
                    end else begin
                        wrap_ring();
                    end
                end else begin
                    first_pass[ring_seg] = 1'b0;
                    ring_seg = nxt[2:0];
                    ring_off = 0;
                    move_count++;
                end
            end
        end
        r.entry_valid    = valid;
        r.segment_index  = ring_seg;
        r.entry_offset   = ring_off[OFF_OUT_W-1:0];
        r.cycle_state    = ring_cycle;
        r.reeval_pending = ring_reeval;
        return r;
    endfunction

    function automatic ring_item_t random_item();
        ring_item_t it;
        it.cmd = ($urandom_range(99) < ADVANCE_PCT) ? CMD_ADVANCE : CMD_CHECK;
        it.entry_cycle = 1'($urandom_range(1));
        case ($urandom_range(5))
            0, 1:    it.entry_code = '0;
            2:       it.entry_code = '1;
            default: it.entry_code = CODE_W'($urandom_range(254, 1));
        endcase
        it.next_first_code = $urandom_range(1) ? '0 : CODE_W'($urandom_range(255, 1));
        it.ring_first_cycle = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic void stage_item(ring_item_t it);
        if (item_wr < ITEM_CAP) begin
            item_mem[item_wr] = it;
            item_wr++;
        end else begin
            $display("%0t: item store full, expected room for %0d got %0d",
                     $time, ITEM_CAP, item_wr);
            error_count++;
        end
    endfunction

    function automatic void report_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s expected %0d got %0d", $time, name, exp_v, act_v);
            error_count++;
        end
    endfunction

    task automatic push_item(input logic cmd, input logic ecycle, input logic [CODE_W-1:0] code,
                             input logic [CODE_W-1:0] ncode, input logic fcycle);
        ring_item_t it;
        it.cmd = cmd;
        it.entry_cycle = ecycle;
        it.entry_code = code;
        it.next_first_code = ncode;
        it.ring_first_cycle = fcycle;
        stage_item(it);
    endtask

    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        if (wr && addr[2] == REG_SEGMENT_COUNT)
            ring_seg_count = wdata[CNT_W-1:0];
        reg_accesses++;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic verify_segment_count();
        logic [PDATA_W-1:0] rd;
        apb_access(1'b0, SEG_COUNT_ADDR, '0, rd);
        if (rd != PDATA_W'(ring_seg_count)) begin
            $display("%0t: segment_count readback expected %0d got %0d",
                     $time, ring_seg_count, rd);
            error_count++;
        end
    endtask

    task automatic set_segment_count(input logic [CNT_W-1:0] count);
        logic [PDATA_W-1:0] rd;
        // Upper bits random: only the low nibble is the register
        apb_access(1'b1, SEG_COUNT_ADDR, {(PDATA_W-CNT_W)'($urandom), count}, rd);
        verify_segment_count();
    endtask

    // Hold until every queued item went in and every result came back.
    task automatic wait_ring_idle();
        @(negedge aclk);
        while (item_wr != item_rd || s_valid || pred_wr != pred_rd)
            @(negedge aclk);
    endtask

    task automatic run_phase(input logic [CNT_W-1:0] count, input int send_idle,
                             input int recv_stall, input int n, input logic pressure);
        wait_ring_idle();
        set_segment_count(count);
        send_idle_pct <= send_idle;
        recv_stall_pct <= recv_stall;
        pressure_armed <= pressure;
        @(posedge aclk);
        repeat (n) stage_item(random_item());
    endtask

    // Input side: record each transfer in the predictor, then offer the next item.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pred_mem[pred_wr] = dequeue_step(offered);
                pred_wr++;
            end
            if (!s_valid || s_ready) begin
                if (item_wr != item_rd && $urandom_range(99) >= send_idle_pct) begin
                    offered = item_mem[item_rd];
                    item_rd++;
                    s_valid <= 1'b1;
                    s_cmd <= offered.cmd;
                    s_entry_cycle <= offered.entry_cycle;
                    s_entry_code <= offered.entry_code;
                    s_next_first_code <= offered.next_first_code;
                    s_ring_first_cycle <= offered.ring_first_cycle;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: backpressure and compare against the oldest prediction.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (pressure_armed && !pressure_done) begin
            m_ready <= 1'b0;
            hold_left <= HOLDOFF_CYCLES;
            pressure_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end

        if (aresetn && m_valid && m_ready) begin
            if (pred_wr == pred_rd) begin
                $display("%0t: result with none pending: seg %0d off %0d", $time,
                         m_segment_index, m_entry_offset);
                error_count++;
            end else begin
                want = pred_mem[pred_rd];
                pred_rd++;
                report_field("entry_valid", want.entry_valid, m_entry_valid);
                report_field("segment_index", want.segment_index, m_segment_index);
                report_field("entry_offset", want.entry_offset, m_entry_offset);
                report_field("cycle_state", want.cycle_state, m_cycle_state);
                report_field("reeval_pending", want.reeval_pending, m_reeval_pending);
                results_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        logic [PDATA_W-1:0] rd;
        ring_seg = '0;
        ring_off = 0;
        ring_cycle = 1'b1;
        ring_reeval = 1'b0;
        first_pass = '1;
        ring_seg_count = SEGMENT_COUNT_RST;

        while (!aresetn) @(posedge aclk);
        verify_segment_count();

        // Field extremes from the reset position on, all on the first pass of segment 0
        push_item(CMD_CHECK, 1'b0, 8'h00, 8'h00, 1'b0);
        push_item(CMD_CHECK, 1'b1, 8'hFF, 8'hFF, 1'b1);
        push_item(CMD_CHECK, 1'b0, 8'h01, 8'h80, 1'b0);
        push_item(CMD_CHECK, 1'b1, 8'h00, 8'h01, 1'b1);
        push_item(CMD_CHECK, 1'b0, 8'h80, 8'h00, 1'b1);
        push_item(CMD_ADVANCE, 1'b0, 8'h00, 8'h00, 1'b0);
        push_item(CMD_ADVANCE, 1'b1, 8'hFF, 8'hFF, 1'b1);
        push_item(CMD_ADVANCE, 1'b0, 8'hFF, 8'h00, 1'b1);
        push_item(CMD_CHECK, 1'b1, 8'h00, 8'h00, 1'b1);
        push_item(CMD_CHECK, 1'b0, 8'h7F, 8'hFF, 1'b0);
        push_item(CMD_ADVANCE, 1'b1, 8'h00, 8'hFF, 1'b0);
        push_item(CMD_CHECK, 1'b1, 8'hFE, 8'h7F, 1'b0);

        run_phase(4'd1, 0, 0, PHASE_ITEMS, 1'b0);
        wait_ring_idle();
        // Write to an unused address must leave segment_count alone
        apb_access(1'b1, UNUSED_ADDR, '1, rd);
        verify_segment_count();
        run_phase(4'd2, 77, 0, PHASE_ITEMS, 1'b0);
        run_phase(4'd15, 0, 77, PHASE_ITEMS, 1'b0);
        run_phase(4'd3, 13, 13, PHASE_ITEMS, 1'b0);
        run_phase(4'd0, 0, 0, PHASE_ITEMS, 1'b1);
        run_phase(4'd8, 13, 13, PHASE_ITEMS, 1'b0);

        wait_ring_idle();
        repeat (4) @(posedge aclk);
        if (pred_wr != pred_rd) begin
            $display("%0t: %0d results never arrived", $time, pred_wr - pred_rd);
            error_count++;
        end

        $display("Run covered %0d results (%0d checks, %0d advances), %0d register accesses",
                 results_checked, check_count, advance_count, reg_accesses);
        $display("Ring events: %0d wraps, %0d segment moves, %0d deferred advances",
                 wrap_count, move_count, defer_count);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> event_ring_dequeue_tracker.f
+incdir+rtl
rtl/erdt_pkg.sv
rtl/event_ring_dequeue_tracker.sv
tb/event_ring_dequeue_tracker_tb.sv
